FILE: rtl/nea_pkg.sv
// ----------------------------------------------------------------------------
// nea_pkg: shared types and constants of the neighbor-exclusion arbiter
// Requester states, control states, register indexes and ring index helpers.
// ----------------------------------------------------------------------------
package nea_pkg;

    localparam int MAX_REQ_DEFAULT = 64;

    // Ring positions and counts are carried in the width of the ring size register.
    localparam int CNT_W     = 7;
    localparam int MEAL_W    = 8;
    localparam int IDX_OUT_W = 6;
    localparam int STATE_W   = 2;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic [CNT_W-1:0]  RING_SIZE_RESET  = 7'd5;
    localparam logic [CNT_W-1:0]  RING_MIN         = 7'd2;
    localparam logic [MEAL_W-1:0] MEAL_QUOTA_RESET = 8'd2;
    localparam logic [MEAL_W-1:0] MEAL_MAX         = 8'hFF;

    typedef enum logic [STATE_W-1:0] {
        RS_THINKING = 2'd0,
        RS_HUNGRY   = 2'd1,
        RS_EATING   = 2'd2,
        RS_DONE     = 2'd3
    } req_state_t;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_COUNT = 2'd1,
        S_IDLE  = 2'd2,
        S_TEST  = 2'd3
    } ctl_state_t;

    typedef enum logic {
        REG_RING_SIZE  = 1'b0,
        REG_MEAL_QUOTA = 1'b1
    } cfg_idx_t;

    function automatic logic [CNT_W-1:0] ring_left(input logic [CNT_W-1:0] i,
                                                   input logic [CNT_W-1:0] n);
        return (i == '0) ? CNT_W'(n - 1'b1) : CNT_W'(i - 1'b1);
    endfunction

    function automatic logic [CNT_W-1:0] ring_right(input logic [CNT_W-1:0] i,
                                                    input logic [CNT_W-1:0] n);
        return (i == CNT_W'(n - 1'b1)) ? '0 : CNT_W'(i + 1'b1);
    endfunction

endpackage

FILE: rtl/nea_ram.sv
// ----------------------------------------------------------------------------
// nea_ram: generic synchronous RAM
// One write port and two read ports, read data registered on read enable.
// ----------------------------------------------------------------------------
module nea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: rtl/neighbor_exclusion_arbiter_top.sv
// ----------------------------------------------------------------------------
// neighbor_exclusion_arbiter_top: ring arbiter where neighbors never eat together
// A pickup tests the requester and gives one beat; a putdown releases it, tests
// its left then its right neighbor and gives two beats. Each test reads the state
// memories and writes back as its result is registered, which a full result slot
// can hold off. Clearing all MAX_REQUESTERS entries after reset, then counting the
// ring's meals, runs with item_ready low; a register write in idle or count recounts.
// ----------------------------------------------------------------------------
module neighbor_exclusion_arbiter_top #(
    parameter int MAX_REQUESTERS = nea_pkg::MAX_REQ_DEFAULT
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nea_pkg::PADDR_W-1:0]  paddr,
    input  logic [nea_pkg::PDATA_W-1:0]  pwdata,
    output logic [nea_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic                         operation,
    input  logic [nea_pkg::IDX_OUT_W-1:0] requester,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic                         grant_valid,
    output logic [nea_pkg::IDX_OUT_W-1:0] granted_index,
    output logic                         all_done,
    output logic                         last_result
);

    import nea_pkg::*;

    localparam int IW = $clog2(MAX_REQUESTERS);
    localparam logic [CNT_W-1:0] RING_CAP = (MAX_REQUESTERS >= (2 ** CNT_W)) ?
                                            {CNT_W{1'b1}} : CNT_W'(MAX_REQUESTERS);
    localparam logic [IW-1:0] CLR_LAST = IW'(MAX_REQUESTERS - 1);

    // Control registers
    ctl_state_t         ctl_reg, ctl_next;
    logic [CNT_W-1:0]   ring_size_reg, ring_size_next;
    logic [MEAL_W-1:0]  meal_quota_reg, meal_quota_next;
    logic [IW-1:0]      clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0]   cnt_addr_reg, cnt_addr_next;
    logic               iss_done_reg, iss_done_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               rd_last_reg, rd_last_next;
    logic [CNT_W-1:0]   fin_cnt_reg, fin_cnt_next;
    logic               result_valid_reg, result_valid_next;

    // Test context and result registers
    logic [CNT_W-1:0]   tst_idx_reg, tst_idx_next;
    logic [CNT_W-1:0]   r_idx_reg, r_idx_next;
    logic [CNT_W-1:0]   who_reg, who_next;
    logic               tst_last_reg, tst_last_next;
    logic               tst_hungry_reg, tst_hungry_next;
    logic               tst_frc_l_reg, tst_frc_l_next;
    logic               tst_frc_r_reg, tst_frc_r_next;
    logic               tst_fwd_self_reg, tst_fwd_self_next;
    logic               tst_fwd_r_reg, tst_fwd_r_next;
    req_state_t         fw_st_reg, fw_st_next;
    logic [MEAL_W-1:0]  fw_ml_reg, fw_ml_next;
    logic               fw_eat_reg, fw_eat_next;
    logic               grant_reg, grant_next;
    logic [IDX_OUT_W-1:0] gidx_reg, gidx_next;
    logic               all_done_reg, all_done_next;
    logic               last_reg, last_next;

    // Memory ports
    logic               st_we, st_re;
    logic [IW-1:0]      st_waddr, st_raddr;
    logic [STATE_W-1:0] st_wdata, st_rdata;
    logic               ml_we, ml_re;
    logic [IW-1:0]      ml_waddr, ml_raddr;
    logic [MEAL_W-1:0]  ml_wdata, ml_rdata;
    logic               eat_we, eat_re;
    logic [IW-1:0]      eat_waddr, eat_raddr_a, eat_raddr_b;
    logic               eat_wdata, eat_rdata_a, eat_rdata_b;

    // Combinational helpers
    logic [CNT_W-1:0]   n_len;
    logic [CNT_W-1:0]   who;
    logic               who_ok;
    logic [CNT_W-1:0]   who_l, who_r, who_ll, r_rr;
    logic               cfg_wr, accept, slot_free, fire, start_count;
    req_state_t         st_cur, st_mid, st_new;
    logic [MEAL_W-1:0]  ml_cur, ml_new;
    logic               eat_l, eat_r, grant, fin_inc;
    logic [CNT_W-1:0]   fin_new;

    nea_ram #(.WIDTH(STATE_W), .DEPTH(MAX_REQUESTERS)) u_st_ram (
        .clk     (clk),
        .we      (st_we),
        .waddr   (st_waddr),
        .wdata   (st_wdata),
        .re_a    (st_re),
        .raddr_a (st_raddr),
        .rdata_a (st_rdata),
        .re_b    (1'b0),
        .raddr_b ('0),
        .rdata_b ()
    );

    nea_ram #(.WIDTH(MEAL_W), .DEPTH(MAX_REQUESTERS)) u_ml_ram (
        .clk     (clk),
        .we      (ml_we),
        .waddr   (ml_waddr),
        .wdata   (ml_wdata),
        .re_a    (ml_re),
        .raddr_a (ml_raddr),
        .rdata_a (ml_rdata),
        .re_b    (1'b0),
        .raddr_b ('0),
        .rdata_b ()
    );

    // Copy of the eating flag, so both neighbors can be read in the same cycle.
    nea_ram #(.WIDTH(1), .DEPTH(MAX_REQUESTERS)) u_eat_ram (
        .clk     (clk),
        .we      (eat_we),
        .waddr   (eat_waddr),
        .wdata   (eat_wdata),
        .re_a    (eat_re),
        .raddr_a (eat_raddr_a),
        .rdata_a (eat_rdata_a),
        .re_b    (eat_re),
        .raddr_b (eat_raddr_b),
        .rdata_b (eat_rdata_b)
    );

    always_comb
    begin
        n_len = (ring_size_reg > RING_CAP) ? RING_CAP : ring_size_reg;
        if (n_len < RING_MIN)
        begin
            n_len = RING_MIN;
        end
    end

    assign who    = CNT_W'(requester);
    assign who_ok = (who < n_len);
    assign who_l  = ring_left(who, n_len);
    assign who_r  = ring_right(who, n_len);
    assign who_ll = ring_left(who_l, n_len);
    assign r_rr   = ring_right(r_idx_reg, n_len);

    assign cfg_wr     = psel && penable && pwrite;
    assign pready     = 1'b1;
    // A register write in the same cycle takes the slot, so no beat is taken then.
    assign item_ready = (ctl_reg == S_IDLE) && !cfg_wr;
    assign accept     = item_valid && item_ready;
    assign slot_free  = !result_valid_reg || result_ready;
    assign fire       = (ctl_reg == S_TEST) && slot_free;
    assign start_count = (cfg_wr && (ctl_reg == S_IDLE || ctl_reg == S_COUNT)) ||
                         (ctl_reg == S_CLEAR && clr_addr_reg == CLR_LAST);

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx_t'(paddr[2]))
            REG_RING_SIZE:  prdata = PDATA_W'(ring_size_reg);
            REG_MEAL_QUOTA: prdata = PDATA_W'(meal_quota_reg);
        endcase
    end

    always_comb
    begin
        ring_size_next  = ring_size_reg;
        meal_quota_next = meal_quota_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx_t'(paddr[2]))
                REG_RING_SIZE:  ring_size_next  = pwdata[CNT_W-1:0];
                REG_MEAL_QUOTA: meal_quota_next = pwdata[MEAL_W-1:0];
            endcase
        end
    end

    // One test: read data (or the value just written for the same entry) in,
    // new state, meal count and result out.
    always_comb
    begin
        st_cur = tst_fwd_self_reg ? fw_st_reg : req_state_t'(st_rdata);
        ml_cur = tst_fwd_self_reg ? fw_ml_reg : ml_rdata;
        if (tst_hungry_reg)
        begin
            st_cur = RS_HUNGRY;
        end
        eat_l   = !tst_frc_l_reg && eat_rdata_a;
        eat_r   = !tst_frc_r_reg && (tst_fwd_r_reg ? fw_eat_reg : eat_rdata_b);
        st_mid  = (ml_cur >= meal_quota_reg) ? RS_DONE : st_cur;
        grant   = (fin_cnt_reg != n_len) && (st_mid == RS_HUNGRY) && !eat_l && !eat_r;
        st_new  = grant ? RS_EATING : st_mid;
        ml_new  = (grant && ml_cur != MEAL_MAX) ? MEAL_W'(ml_cur + 1'b1) : ml_cur;
        fin_inc = grant && (ml_cur != MEAL_MAX) && (MEAL_W'(ml_cur + 1'b1) == meal_quota_reg);
        fin_new = CNT_W'(fin_cnt_reg + CNT_W'(fin_inc));
    end

    always_comb
    begin
        ctl_next = ctl_reg;
        unique case (ctl_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == CLR_LAST)
                begin
                    ctl_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                if (!cfg_wr && rd_pend_reg && rd_last_reg)
                begin
                    ctl_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cfg_wr)
                begin
                    ctl_next = S_COUNT;
                end
                else if (accept && who_ok)
                begin
                    ctl_next = S_TEST;
                end
            end
            S_TEST:
            begin
                if (fire && tst_last_reg)
                begin
                    ctl_next = S_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        clr_addr_next     = clr_addr_reg;
        cnt_addr_next     = cnt_addr_reg;
        iss_done_next     = iss_done_reg;
        rd_pend_next      = 1'b0;
        rd_last_next      = rd_last_reg;
        fin_cnt_next      = fin_cnt_reg;
        tst_idx_next      = tst_idx_reg;
        r_idx_next        = r_idx_reg;
        who_next          = who_reg;
        tst_last_next     = tst_last_reg;
        tst_hungry_next   = tst_hungry_reg;
        tst_frc_l_next    = tst_frc_l_reg;
        tst_frc_r_next    = tst_frc_r_reg;
        tst_fwd_self_next = tst_fwd_self_reg;
        tst_fwd_r_next    = tst_fwd_r_reg;
        fw_st_next        = fw_st_reg;
        fw_ml_next        = fw_ml_reg;
        fw_eat_next       = fw_eat_reg;
        grant_next        = grant_reg;
        gidx_next         = gidx_reg;
        all_done_next     = all_done_reg;
        last_next         = last_reg;
        result_valid_next = result_valid_reg && !result_ready;

        st_we       = 1'b0;
        st_waddr    = IW'(tst_idx_reg);
        st_wdata    = st_new;
        st_re       = 1'b0;
        st_raddr    = IW'(who);
        ml_we       = 1'b0;
        ml_waddr    = IW'(tst_idx_reg);
        ml_wdata    = ml_new;
        ml_re       = 1'b0;
        ml_raddr    = IW'(who);
        eat_we      = 1'b0;
        eat_waddr   = IW'(tst_idx_reg);
        // A putdown's neighbor that was already eating and is not done stays eating.
        eat_wdata   = (st_new == RS_EATING);
        eat_re      = 1'b0;
        eat_raddr_a = IW'(who_l);
        eat_raddr_b = IW'(who_r);

        case (ctl_reg)
            S_CLEAR:
            begin
                st_we         = 1'b1;
                st_waddr      = clr_addr_reg;
                st_wdata      = RS_THINKING;
                ml_we         = 1'b1;
                ml_waddr      = clr_addr_reg;
                ml_wdata      = '0;
                eat_we        = 1'b1;
                eat_waddr     = clr_addr_reg;
                eat_wdata     = 1'b0;
                clr_addr_next = IW'(clr_addr_reg + 1'b1);
            end
            S_COUNT:
            begin
                // Sweep the meal counts of the ring; the read data is registered and counted on return.
                if (!iss_done_reg)
                begin
                    ml_re         = 1'b1;
                    ml_raddr      = IW'(cnt_addr_reg);
                    rd_pend_next  = 1'b1;
                    rd_last_next  = (cnt_addr_reg == CNT_W'(n_len - 1'b1));
                    iss_done_next = (cnt_addr_reg == CNT_W'(n_len - 1'b1));
                    cnt_addr_next = CNT_W'(cnt_addr_reg + 1'b1);
                end
                if (rd_pend_reg)
                begin
                    fin_cnt_next = CNT_W'(fin_cnt_reg + CNT_W'(ml_rdata >= meal_quota_reg));
                end
            end
            S_IDLE:
            begin
                if (accept && who_ok && !cfg_wr)
                begin
                    who_next          = who;
                    tst_fwd_self_next = 1'b0;
                    tst_fwd_r_next    = 1'b0;
                    if (operation == 1'b0)
                    begin
                        // Pickup: the requester is hungry and tested at once.
                        st_re           = 1'b1;
                        ml_re           = 1'b1;
                        eat_re          = 1'b1;
                        tst_idx_next    = who;
                        tst_last_next   = 1'b1;
                        tst_hungry_next = 1'b1;
                        tst_frc_l_next  = 1'b0;
                        tst_frc_r_next  = 1'b0;
                    end
                    else
                    begin
                        // Putdown: release the requester, then test its left neighbor.
                        st_we           = 1'b1;
                        st_waddr        = IW'(who);
                        st_wdata        = RS_THINKING;
                        eat_we          = 1'b1;
                        eat_waddr       = IW'(who);
                        eat_wdata       = 1'b0;
                        st_re           = 1'b1;
                        st_raddr        = IW'(who_l);
                        ml_re           = 1'b1;
                        ml_raddr        = IW'(who_l);
                        eat_re          = 1'b1;
                        eat_raddr_a     = IW'(who_ll);
                        eat_raddr_b     = IW'(who);
                        tst_idx_next    = who_l;
                        r_idx_next      = who_r;
                        tst_last_next   = 1'b0;
                        tst_hungry_next = 1'b0;
                        // In a ring of two the left neighbor's left is the releaser.
                        tst_frc_l_next  = (n_len == RING_MIN);
                        tst_frc_r_next  = 1'b1;
                    end
                end
            end
            S_TEST:
            begin
                if (fire)
                begin
                    st_we             = 1'b1;
                    ml_we             = 1'b1;
                    eat_we            = 1'b1;
                    fin_cnt_next      = fin_new;
                    result_valid_next = 1'b1;
                    grant_next        = grant;
                    gidx_next         = tst_idx_reg[IDX_OUT_W-1:0];
                    all_done_next     = (fin_new == n_len);
                    last_next         = tst_last_reg;
                    if (!tst_last_reg)
                    begin
                        // Issue the right neighbor's reads while the left one is
                        // written back; overlapping entries are forwarded.
                        st_re             = 1'b1;
                        st_raddr          = IW'(r_idx_reg);
                        ml_re             = 1'b1;
                        ml_raddr          = IW'(r_idx_reg);
                        eat_re            = 1'b1;
                        eat_raddr_a       = IW'(who_reg);
                        eat_raddr_b       = IW'(r_rr);
                        tst_idx_next      = r_idx_reg;
                        tst_last_next     = 1'b1;
                        tst_hungry_next   = 1'b0;
                        tst_frc_l_next    = 1'b1;
                        tst_frc_r_next    = 1'b0;
                        tst_fwd_self_next = (r_idx_reg == tst_idx_reg);
                        tst_fwd_r_next    = (r_rr == tst_idx_reg);
                        fw_st_next        = st_new;
                        fw_ml_next        = ml_new;
                        fw_eat_next       = (st_new == RS_EATING);
                    end
                end
            end
            default:
            begin
                clr_addr_next = clr_addr_reg;
            end
        endcase

        if (start_count)
        begin
            cnt_addr_next = '0;
            iss_done_next = 1'b0;
            rd_pend_next  = 1'b0;
            fin_cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg          <= S_CLEAR;
            ring_size_reg    <= RING_SIZE_RESET;
            meal_quota_reg   <= MEAL_QUOTA_RESET;
            clr_addr_reg     <= '0;
            cnt_addr_reg     <= '0;
            iss_done_reg     <= 1'b0;
            rd_pend_reg      <= 1'b0;
            rd_last_reg      <= 1'b0;
            fin_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            ctl_reg          <= ctl_next;
            ring_size_reg    <= ring_size_next;
            meal_quota_reg   <= meal_quota_next;
            clr_addr_reg     <= clr_addr_next;
            cnt_addr_reg     <= cnt_addr_next;
            iss_done_reg     <= iss_done_next;
            rd_pend_reg      <= rd_pend_next;
            rd_last_reg      <= rd_last_next;
            fin_cnt_reg      <= fin_cnt_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tst_idx_reg      <= tst_idx_next;
        r_idx_reg        <= r_idx_next;
        who_reg          <= who_next;
        tst_last_reg     <= tst_last_next;
        tst_hungry_reg   <= tst_hungry_next;
        tst_frc_l_reg    <= tst_frc_l_next;
        tst_frc_r_reg    <= tst_frc_r_next;
        tst_fwd_self_reg <= tst_fwd_self_next;
        tst_fwd_r_reg    <= tst_fwd_r_next;
        fw_st_reg        <= fw_st_next;
        fw_ml_reg        <= fw_ml_next;
        fw_eat_reg       <= fw_eat_next;
        grant_reg        <= grant_next;
        gidx_reg         <= gidx_next;
        all_done_reg     <= all_done_next;
        last_reg         <= last_next;
    end

    assign result_valid  = result_valid_reg;
    assign grant_valid   = grant_reg;
    assign granted_index = gidx_reg;
    assign all_done      = all_done_reg;
    assign last_result   = last_reg;

endmodule

FILE: test/tb_neighbor_exclusion_arbiter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_neighbor_exclusion_arbiter_top: self-checking bench for the ring arbiter
// Pickup and putdown beats run through ring and quota settings written over the
// APB port. Bursty sender, stalling receiver, and an in-bench model of the
// arbitration state that predicts every result beat.
// ----------------------------------------------------------------------------
module tb_neighbor_exclusion_arbiter_top;
    import nea_pkg::*;

    localparam int MAX_REQ     = MAX_REQ_DEFAULT;
    localparam int HOLD_CYCLES = 400;
    localparam int LIMIT       = 300000;
    localparam int REPORT_CAP  = 100;

    typedef enum logic {
        OP_PICKUP  = 1'b0,
        OP_PUTDOWN = 1'b1
    } ring_op_t;

    typedef enum int {
        RX_ALWAYS  = 0,
        RX_RANDOM  = 1,
        RX_PATTERN = 2
    } rx_mode_t;

    typedef struct packed {
        ring_op_t               op;
        logic [IDX_OUT_W-1:0]   who;
    } ring_event_t;

    typedef struct packed {
        logic                   grant;
        logic [IDX_OUT_W-1:0]   idx;
        logic                   done;
        logic                   last;
    } test_outcome_t;

    logic                   clk;
    logic                   rst_n;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [PADDR_W-1:0]     paddr;
    logic [PDATA_W-1:0]     pwdata;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;
    logic                   item_valid;
    logic                   item_ready;
    logic                   operation;
    logic [IDX_OUT_W-1:0]   requester;
    logic                   result_valid;
    logic                   result_ready;
    logic                   grant_valid;
    logic [IDX_OUT_W-1:0]   granted_index;
    logic                   all_done;
    logic                   last_result;

    // Model of the arbitration state and the register shadows.
    req_state_t             seat_state [MAX_REQ];
    logic [MEAL_W-1:0]      meals [MAX_REQ];
    logic [CNT_W-1:0]       ring_size_cfg;
    logic [MEAL_W-1:0]      quota_cfg;

    ring_event_t            event_q [$];
    test_outcome_t          outcome_q [$];
    int                     queued_beats;
    int                     accepted_beats;
    int                     mismatches;
    int                     gap_max;
    rx_mode_t               rx_mode;
    bit                     hold_asked;
    bit                     hold_taken;
    int                     burst_left;
    int                     gap_left;
    int                     hold_left;
    int                     rx_phase;
    int                     watchdog_cycles;
    ring_event_t            next_event;
    test_outcome_t          want;
    logic                   ready_next;

    neighbor_exclusion_arbiter_top #(
        .MAX_REQUESTERS(MAX_REQ)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .operation    (operation),
        .requester    (requester),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .grant_valid  (grant_valid),
        .granted_index(granted_index),
        .all_done     (all_done),
        .last_result  (last_result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned active_ring();
        int unsigned n;
        n = ring_size_cfg;
        if (n > MAX_REQ)
            n = MAX_REQ;
        if (n < 2)
            n = 2;
        return n;
    endfunction

    function automatic int unsigned sated_count(int unsigned n);
        int unsigned c;
        c = 0;
        for (int unsigned k = 0; k < n; k++)
            if (meals[k] >= quota_cfg)
                c++;
        return c;
    endfunction

    // One neighbor test: mark done at quota, then grant if hungry and both
    // neighbors are off the resource, unless the whole ring was already sated.
    function automatic void test_seat(int unsigned idx, int unsigned n, bit last);
        int unsigned   left;
        int unsigned   right;
        bit            everyone_sated;
        test_outcome_t res;
        left = (idx + n - 1) % n;
        right = (idx + 1) % n;
        everyone_sated = (sated_count(n) == n);
        res.grant = 1'b0;
        if (meals[idx] >= quota_cfg)
            seat_state[idx] = RS_DONE;
        if (!everyone_sated && seat_state[idx] == RS_HUNGRY &&
            seat_state[left] != RS_EATING && seat_state[right] != RS_EATING)
        begin
            seat_state[idx] = RS_EATING;
            if (meals[idx] != MEAL_MAX)
                meals[idx] = meals[idx] + 1'b1;
            res.grant = 1'b1;
        end
        res.idx = IDX_OUT_W'(idx);
        res.done = (sated_count(n) == n);
        res.last = last;
        outcome_q.push_back(res);
    endfunction

    function automatic void predict_event(ring_op_t op, int unsigned who);
        int unsigned n;
        n = active_ring();
        if (who >= n)
            return;
        if (op == OP_PICKUP)
        begin
            seat_state[who] = RS_HUNGRY;
            test_seat(who, n, 1'b1);
        end
        else
        begin
            seat_state[who] = RS_THINKING;
            test_seat((who + n - 1) % n, n, 1'b0);
            test_seat((who + 1) % n, n, 1'b1);
        end
    endfunction

    function automatic void check_field(string name, int exp_v, int act_v, bit unknown);
        if (unknown || exp_v != act_v)
        begin
            mismatches++;
            if (mismatches <= REPORT_CAP)
                $error("%s mismatch: expected %0d, got %0d%s", name, exp_v, act_v,
                       unknown ? " (X/Z)" : "");
        end
    endfunction

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            operation <= 1'b0;
            requester <= '0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                accepted_beats++;
                predict_event(ring_op_t'(operation), requester);
            end
            if (!item_valid || item_ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    item_valid <= 1'b0;
                end
                else if (event_q.size() != 0)
                begin
                    next_event = event_q.pop_front();
                    item_valid <= 1'b1;
                    operation <= next_event.op;
                    requester <= next_event.who;
                    if (burst_left > 0)
                        burst_left--;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                    end
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks every result beat and, by mode, stalls at random or on a pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left = 0;
            rx_phase = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (outcome_q.size() == 0)
                begin
                    mismatches++;
                    $error("result beat with nothing pending: index %0d", granted_index);
                end
                else
                begin
                    want = outcome_q.pop_front();
                    check_field("grant_valid", want.grant, grant_valid, $isunknown(grant_valid));
                    check_field("granted_index", want.idx, granted_index,
                                $isunknown(granted_index));
                    check_field("all_done", want.done, all_done, $isunknown(all_done));
                    check_field("last_result", want.last, last_result, $isunknown(last_result));
                end
            end
            if (hold_asked && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            rx_phase = (rx_phase == 6) ? 0 : rx_phase + 1;
            if (hold_left != 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_ALWAYS: ready_next = 1'b1;
                    RX_RANDOM: ready_next = ($urandom_range(0, 2) != 0);
                    default:   ready_next = (rx_phase != 2 && rx_phase != 5);
                endcase
            end
            result_ready <= ready_next;
        end
    end

    task automatic add_event(ring_op_t op, int unsigned who);
        ring_event_t ev;
        ev.op = op;
        ev.who = IDX_OUT_W'(who);
        event_q.push_back(ev);
        queued_beats++;
    endtask

    // Mostly pickups followed later by putdowns of the same requesters, with a
    // sprinkle of arbitrary beats that may fall outside the ring.
    task automatic add_random_events(int count);
        bit [MAX_REQ-1:0] holding;
        int unsigned      n;
        int unsigned      who;
        int unsigned      roll;
        holding = '0;
        n = active_ring();
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 6)
            begin
                add_event(ring_op_t'($urandom_range(0, 1)), $urandom_range(0, MAX_REQ - 1));
            end
            else if (roll < 55)
            begin
                who = $urandom_range(0, n - 1);
                holding[who] = 1'b1;
                add_event(OP_PICKUP, who);
            end
            else
            begin
                who = $urandom_range(0, n - 1);
                repeat (8)
                    if (!holding[who])
                        who = $urandom_range(0, n - 1);
                holding[who] = 1'b0;
                add_event(OP_PUTDOWN, who);
            end
        end
    endtask

    task automatic write_reg(cfg_idx_t which, logic [PDATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(4 * int'(which));
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (which == REG_RING_SIZE)
            ring_size_cfg = value[CNT_W-1:0];
        else
            quota_cfg = value[MEAL_W-1:0];
    endtask

    // Waits until every beat is taken and every result has come back, then
    // gives the design idle clocks before the next settings are written.
    task automatic wait_idle();
        while (accepted_beats != queued_beats || outcome_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_traffic(int gaps, rx_mode_t mode);
        gap_max = gaps;
        rx_mode = mode;
    endtask

    initial
    begin
        watchdog_cycles = 0;
        while (watchdog_cycles < LIMIT)
        begin
            @(posedge clk);
            watchdog_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        queued_beats = 0;
        accepted_beats = 0;
        mismatches = 0;
        hold_asked = 1'b0;
        hold_taken = 1'b0;
        ring_size_cfg = RING_SIZE_RESET;
        quota_cfg = MEAL_QUOTA_RESET;
        for (int k = 0; k < MAX_REQ; k++)
        begin
            seat_state[k] = RS_THINKING;
            meals[k] = '0;
        end
        set_traffic(3, RX_RANDOM);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings: grants, neighbor denials, a meal quota reached,
        // repeated pickups and beats from outside the ring.
        add_event(OP_PICKUP, 0);
        add_event(OP_PICKUP, 1);
        add_event(OP_PICKUP, 4);
        add_event(OP_PUTDOWN, 0);
        add_event(OP_PICKUP, 2);
        add_event(OP_PUTDOWN, 1);
        add_event(OP_PICKUP, 0);
        add_event(OP_PICKUP, 0);
        add_event(OP_PUTDOWN, 4);
        add_event(OP_PUTDOWN, 0);
        add_event(OP_PICKUP, 0);
        add_event(OP_PICKUP, 5);
        add_event(OP_PICKUP, 63);
        add_event(OP_PUTDOWN, 63);
        add_event(OP_PICKUP, 3);
        add_event(OP_PUTDOWN, 2);
        add_event(OP_PUTDOWN, 3);
        add_random_events(150);
        wait_idle();

        // Ring of two: both neighbor tests land on the same requester.
        write_reg(REG_RING_SIZE, 2);
        write_reg(REG_MEAL_QUOTA, 1);
        set_traffic(0, RX_ALWAYS);
        add_event(OP_PICKUP, 0);
        add_event(OP_PICKUP, 1);
        add_event(OP_PUTDOWN, 0);
        add_event(OP_PICKUP, 0);
        add_event(OP_PUTDOWN, 1);
        add_event(OP_PICKUP, 2);
        add_random_events(120);
        wait_idle();

        // Ring size below the minimum and a quota of zero: never a grant.
        write_reg(REG_RING_SIZE, 0);
        write_reg(REG_MEAL_QUOTA, 0);
        set_traffic(6, RX_PATTERN);
        add_event(OP_PICKUP, 0);
        add_event(OP_PUTDOWN, 1);
        add_event(OP_PICKUP, 1);
        add_random_events(60);
        wait_idle();

        // Full ring with the largest quota; the receiver holds off for a long
        // stretch so that the arbiter backs up into its input.
        write_reg(REG_RING_SIZE, 64);
        write_reg(REG_MEAL_QUOTA, 255);
        set_traffic(0, RX_RANDOM);
        hold_asked = 1'b1;
        add_random_events(500);
        wait_idle();

        write_reg(REG_RING_SIZE, 127);
        write_reg(REG_MEAL_QUOTA, 3);
        set_traffic(2, RX_PATTERN);
        add_random_events(300);
        wait_idle();

        // Lower the quota with meals already counted.
        write_reg(REG_MEAL_QUOTA, 1);
        set_traffic(4, RX_RANDOM);
        add_random_events(100);
        wait_idle();

        write_reg(REG_RING_SIZE, 1);
        write_reg(REG_MEAL_QUOTA, 255);
        set_traffic(0, RX_ALWAYS);
        add_random_events(100);
        wait_idle();

        write_reg(REG_RING_SIZE, 3);
        write_reg(REG_MEAL_QUOTA, $urandom_range(1, 4));
        set_traffic(5, RX_RANDOM);
        add_random_events(250);
        wait_idle();

        write_reg(REG_RING_SIZE, $urandom_range(2, 64));
        write_reg(REG_MEAL_QUOTA, $urandom_range(1, 8));
        set_traffic(3, RX_PATTERN);
        add_random_events(400);
        wait_idle();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && outcome_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/nea_pkg.sv
rtl/nea_ram.sv
rtl/neighbor_exclusion_arbiter_top.sv
test/tb_neighbor_exclusion_arbiter_top.sv
